FILE: rtl/fpp_pkg.sv
package fpp_pkg;

    // Widths of the parser state.
    localparam int CNT_W  = 17;
    localparam int CRC_W  = 16;
    localparam int SIZE_W = 16;
    localparam int CTRL_W = 6;

    // Configuration port geometry.
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_HEAD_BYTE   = 2'd0;
    localparam logic [1:0] REG_MAX_VERSION = 2'd1;
    localparam logic [1:0] REG_MAX_PAYLOAD = 2'd2;

    // Register reset values.
    localparam logic [7:0]        HEAD_BYTE_RST   = 8'h5A;
    localparam logic [7:0]        MAX_VERSION_RST = 8'd1;
    localparam logic [SIZE_W-1:0] MAX_PAYLOAD_RST = 16'd256;

    // Header length in bytes, head included, without and with the address byte.
    localparam logic [CNT_W-1:0] HDR_NOADDR = CNT_W'(7);
    localparam logic [CNT_W-1:0] HDR_ADDR   = CNT_W'(8);
    localparam logic [CNT_W-1:0] CRC_LEN    = CNT_W'(2);

    // Control byte layout.
    localparam int CTRL_ADDR_BIT = 5;
    localparam int CTRL_DATA_BIT = 4;

    // CRC-16/XMODEM generator polynomial.
    localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

    typedef enum logic [3:0] {
        PH_HUNT = 4'd0,
        PH_TYPE = 4'd1,
        PH_VER  = 4'd2,
        PH_CTRL = 4'd3,
        PH_MID  = 4'd4,
        PH_ADDR = 4'd5,
        PH_SIZE = 4'd6,
        PH_DATA = 4'd7,
        PH_CRC  = 4'd8
    } t_phase;

    typedef enum logic [2:0] {
        EV_HUNT      = 3'd0,
        EV_HEADER    = 3'd1,
        EV_PAYLOAD   = 3'd2,
        EV_CRC_BYTE  = 3'd3,
        EV_FRAME_OK  = 3'd4,
        EV_VER_ERR   = 3'd5,
        EV_SIZE_ERR  = 3'd6,
        EV_CRC_ERR   = 3'd7
    } t_event;

    typedef struct packed {
        logic [7:0]        head_byte;
        logic [7:0]        max_version;
        logic [SIZE_W-1:0] max_payload;
    } t_cfg;

    typedef struct packed {
        t_event            event_res;
        logic [7:0]        byte_echo;
        logic [7:0]        frame_type;
        logic [7:0]        frame_version;
        logic              addressed;
        logic              data_bit;
        logic [3:0]        frame_class;
        logic [7:0]        message_id;
        logic [7:0]        device_addr;
        logic [SIZE_W-1:0] payload_size;
        logic [CRC_W-1:0]  computed_crc;
    } t_result;

    // One byte of CRC-16/XMODEM, MSB first, eight shift steps unrolled.
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [7:0] data);
        logic [CRC_W-1:0] c;
        c = crc ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[CRC_W-1]) begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

FILE: rtl/framed_packet_parser_crc16.sv
// Framed packet parser with a CRC-16/XMODEM check.
// Input channel: one received byte per transaction on i_rx_byte, with
// i_in_valid / o_in_stall. Output channel: one event per input byte, with
// o_out_valid / i_out_stall, carrying the event code, the consumed byte and
// the frame fields captured so far, plus the running CRC.
// Throughput is one byte per clock while the receiver does not stall. A byte
// accepted into the input register is parsed by combinational logic (bytewise
// CRC update, field capture and the size and CRC compares) and lands in the
// result register, from which its event is offered.
// When the receiver stalls, the result register holds its transaction and the
// input register can still take one more byte; o_in_stall rises only once
// both are full, and the input register refills in the cycle a result leaves.
// The head byte, maximum version and maximum payload size are written through
// the APB port at byte addresses 0, 4 and 8, by the user only while the parser
// is idle; the block itself does not enforce this. Synchronous active-low reset
// empties both registers, restores the register defaults (head 0x5A, version 1,
// payload 256) and starts hunting with all captured fields and the CRC at zero.
module framed_packet_parser_crc16
    import fpp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Byte stream in
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [7:0]        i_rx_byte,
    // Events out
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [2:0]        o_event_res,
    output logic [7:0]        o_byte_echo,
    output logic [7:0]        o_frame_type,
    output logic [7:0]        o_frame_version,
    output logic              o_addressed,
    output logic              o_data_bit,
    output logic [3:0]        o_frame_class,
    output logic [7:0]        o_message_id,
    output logic [7:0]        o_device_addr,
    output logic [SIZE_W-1:0] o_payload_size,
    output logic [CRC_W-1:0]  o_computed_crc,
    // Configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    t_cfg       w_cfg;
    t_result    w_res;
    logic       w_advance;
    logic       w_accept;
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    fpp_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Input register: refills in the same cycle the parser takes its byte.
    assign o_in_stall = r_in_valid && !w_advance;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_byte <= i_rx_byte;
        end
    end

    fpp_parse_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_item_valid (r_in_valid),
        .i_item_byte  (r_in_byte),
        .o_advance    (w_advance),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_res        (w_res)
    );

    // Result fields out.
    assign o_event_res     = w_res.event_res;
    assign o_byte_echo     = w_res.byte_echo;
    assign o_frame_type    = w_res.frame_type;
    assign o_frame_version = w_res.frame_version;
    assign o_addressed     = w_res.addressed;
    assign o_data_bit      = w_res.data_bit;
    assign o_frame_class   = w_res.frame_class;
    assign o_message_id    = w_res.message_id;
    assign o_device_addr   = w_res.device_addr;
    assign o_payload_size  = w_res.payload_size;
    assign o_computed_crc  = w_res.computed_crc;

endmodule

FILE: rtl/fpp_apb_regs.sv
module fpp_apb_regs
    import fpp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic [7:0]        r_head_byte;
    logic [7:0]        r_max_version;
    logic [SIZE_W-1:0] r_max_payload;
    logic [1:0]        w_index;
    logic              w_write;

    assign w_index = paddr[3:2];
    assign w_write = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Register writes complete in the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_byte   <= HEAD_BYTE_RST;
            r_max_version <= MAX_VERSION_RST;
            r_max_payload <= MAX_PAYLOAD_RST;
        end else if (w_write) begin
            unique case (w_index)
                REG_HEAD_BYTE:   r_head_byte   <= pwdata[7:0];
                REG_MAX_VERSION: r_max_version <= pwdata[7:0];
                REG_MAX_PAYLOAD: r_max_payload <= pwdata[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // Read data mux.
    always_comb begin
        unique case (w_index)
            REG_HEAD_BYTE:   prdata = {24'd0, r_head_byte};
            REG_MAX_VERSION: prdata = {24'd0, r_max_version};
            REG_MAX_PAYLOAD: prdata = {16'd0, r_max_payload};
            default:         prdata = '0;
        endcase
    end

    assign o_cfg.head_byte   = r_head_byte;
    assign o_cfg.max_version = r_max_version;
    assign o_cfg.max_payload = r_max_payload;

endmodule

FILE: rtl/fpp_parse_core.sv
module fpp_parse_core
    import fpp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_item_valid,
    input  logic [7:0] i_item_byte,
    output logic       o_advance,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_result    o_res
);

    t_phase            r_phase,      n_phase;
    logic [CNT_W-1:0]  r_byte_count, n_byte_count;
    logic [CRC_W-1:0]  r_run_crc,    n_run_crc;
    logic [CRC_W-1:0]  r_rx_crc,     n_rx_crc;
    logic [SIZE_W-1:0] r_size,       n_size;
    logic [7:0]        r_type,       n_type;
    logic [7:0]        r_version,    n_version;
    logic [CTRL_W-1:0] r_control,    n_control;
    logic [7:0]        r_mid,        n_mid;
    logic [7:0]        r_addr,       n_addr;
    logic              r_out_valid;
    t_result           r_res,        n_res;
    t_event            w_event;
    logic              w_err;

    logic              w_load;
    logic [CNT_W-1:0]  w_hdr;
    logic [CNT_W-1:0]  w_cnt_inc;
    logic [CNT_W-1:0]  w_data_last;
    logic [SIZE_W-1:0] w_size_new;
    logic [CRC_W-1:0]  w_rx_crc_new;
    logic [CRC_W-1:0]  w_crc_next;
    logic              w_head_hit;
    logic              w_size_done;
    logic              w_data_done;
    logic              w_crc_done;

    // The result register frees up when empty or when its transaction leaves.
    assign o_advance = !r_out_valid || !i_out_stall;
    assign w_load    = i_item_valid && o_advance;

    // Shared byte position and field arithmetic.
    assign w_hdr        = r_control[CTRL_ADDR_BIT] ? HDR_ADDR : HDR_NOADDR;
    assign w_cnt_inc    = r_byte_count + CNT_W'(1);
    assign w_data_last  = w_hdr + CNT_W'(r_size);
    assign w_size_new   = {r_size[7:0], i_item_byte};
    assign w_rx_crc_new = {r_rx_crc[7:0], i_item_byte};
    assign w_crc_next   = crc_byte(r_run_crc, i_item_byte);
    assign w_head_hit   = (i_item_byte == i_cfg.head_byte);
    assign w_size_done  = (w_cnt_inc >= w_hdr);
    assign w_data_done  = (w_cnt_inc >= w_data_last);
    assign w_crc_done   = (w_cnt_inc >= w_data_last + CRC_LEN);

    // Next phase.
    always_comb begin
        unique case (r_phase)
            PH_HUNT: n_phase = w_head_hit ? PH_TYPE : PH_HUNT;
            PH_TYPE: n_phase = PH_VER;
            PH_VER:  n_phase = (i_item_byte <= i_cfg.max_version) ? PH_CTRL : PH_HUNT;
            PH_CTRL: n_phase = PH_MID;
            PH_MID:  n_phase = r_control[CTRL_ADDR_BIT] ? PH_ADDR : PH_SIZE;
            PH_ADDR: n_phase = PH_SIZE;
            PH_SIZE: begin
                if (!w_size_done) begin
                    n_phase = PH_SIZE;
                end else if (w_size_new > i_cfg.max_payload) begin
                    n_phase = PH_HUNT;
                end else if (w_size_new == '0) begin
                    n_phase = PH_CRC;
                end else begin
                    n_phase = PH_DATA;
                end
            end
            PH_DATA: n_phase = w_data_done ? PH_CRC : PH_DATA;
            PH_CRC:  n_phase = w_crc_done ? PH_HUNT : PH_CRC;
            default: n_phase = PH_HUNT;
        endcase
    end

    // Field capture, CRC, byte count and event code.
    always_comb begin
        n_byte_count = r_byte_count;
        n_run_crc    = r_run_crc;
        n_rx_crc     = r_rx_crc;
        n_size       = r_size;
        n_type       = r_type;
        n_version    = r_version;
        n_control    = r_control;
        n_mid        = r_mid;
        n_addr       = r_addr;
        w_event      = EV_HEADER;
        w_err        = 1'b0;

        // The CRC covers every byte from the type byte to the last payload byte.
        if (r_phase != PH_HUNT && r_phase != PH_CRC) begin
            n_run_crc = w_crc_next;
        end
        if (r_phase != PH_HUNT) begin
            n_byte_count = w_cnt_inc;
        end

        unique case (r_phase)
            PH_HUNT: begin
                if (w_head_hit) begin
                    n_byte_count = CNT_W'(1);
                    n_run_crc    = '0;
                    n_rx_crc     = '0;
                    n_size       = '0;
                end else begin
                    w_event = EV_HUNT;
                end
            end
            PH_TYPE: n_type = i_item_byte;
            PH_VER: begin
                n_version = i_item_byte;
                if (i_item_byte > i_cfg.max_version) begin
                    w_event = EV_VER_ERR;
                    w_err   = 1'b1;
                end
            end
            PH_CTRL: n_control = i_item_byte[CTRL_W-1:0];
            PH_MID: begin
                n_mid = i_item_byte;
                if (!r_control[CTRL_ADDR_BIT]) begin
                    n_addr = '0;
                end
            end
            PH_ADDR: n_addr = i_item_byte;
            PH_SIZE: begin
                n_size = w_size_new;
                if (w_size_done && w_size_new > i_cfg.max_payload) begin
                    w_event = EV_SIZE_ERR;
                    w_err   = 1'b1;
                end
            end
            PH_DATA: w_event = EV_PAYLOAD;
            PH_CRC: begin
                w_event  = EV_CRC_BYTE;
                n_rx_crc = w_rx_crc_new;
                if (w_crc_done) begin
                    if (w_rx_crc_new == r_run_crc) begin
                        w_event      = EV_FRAME_OK;
                        n_byte_count = '0;
                    end else begin
                        w_event = EV_CRC_ERR;
                        w_err   = 1'b1;
                    end
                end
            end
            default: w_event = EV_HUNT;
        endcase
    end

    // Result fields show the registers including the byte just consumed.
    always_comb begin
        n_res.event_res     = w_event;
        n_res.byte_echo     = i_item_byte;
        n_res.frame_type    = n_type;
        n_res.frame_version = n_version;
        n_res.addressed     = n_control[CTRL_ADDR_BIT];
        n_res.data_bit      = n_control[CTRL_DATA_BIT];
        n_res.frame_class   = n_control[3:0];
        n_res.message_id    = n_mid;
        n_res.device_addr   = n_addr;
        n_res.payload_size  = n_size;
        n_res.computed_crc  = n_run_crc;
    end

    // Parser state; an error drops the count and the size, the size after reporting it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HUNT;
            r_byte_count <= '0;
            r_run_crc    <= '0;
            r_rx_crc     <= '0;
            r_size       <= '0;
            r_type       <= '0;
            r_version    <= '0;
            r_control    <= '0;
            r_mid        <= '0;
            r_addr       <= '0;
        end else if (w_load) begin
            r_phase      <= n_phase;
            r_byte_count <= w_err ? '0 : n_byte_count;
            r_run_crc    <= n_run_crc;
            r_rx_crc     <= n_rx_crc;
            r_size       <= w_err ? '0 : n_size;
            r_type       <= n_type;
            r_version    <= n_version;
            r_control    <= n_control;
            r_mid        <= n_mid;
            r_addr       <= n_addr;
        end
    end

    // Result register valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_advance) begin
            r_out_valid <= i_item_valid;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_res       = r_res;

    // A good frame rearms the parser with a cleared byte count.
    a_ok_rearms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_event == EV_FRAME_OK) |=> (r_phase == PH_HUNT && r_byte_count == '0))
        else $error("parser did not rearm after a good frame");

    // Every error returns to hunting with count and size cleared.
    a_err_hunts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_err) |=> (r_phase == PH_HUNT && r_byte_count == '0 && r_size == '0))
        else $error("parser did not return to hunting after an error");

    // The payload phase never runs past its last byte.
    a_data_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_byte_count < w_data_last && r_size != '0))
        else $error("payload byte count past declared size");

    // A payload event comes only from the payload phase.
    a_payload_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_event == EV_PAYLOAD) |-> (r_phase == PH_DATA))
        else $error("payload event outside payload phase");

    // A held result does not change while the receiver stalls.
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_res)))
        else $error("stalled result changed");

endmodule

FILE: tb/tb_framed_packet_parser_crc16.sv
`timescale 1ns / 1ps

module tb_framed_packet_parser_crc16;
    import fpp_pkg::*;

    localparam int          IDLE_PCT       = 23;
    localparam int          MAX_REPORTS    = 10;
    localparam int          CYCLE_LIMIT    = 1000000;
    localparam int          SETTLE_CYCLES  = 4;
    localparam logic [1:0]  REG_UNUSED     = 2'd3;
    localparam logic [16:0] HDR_LEN_NOADDR = 17'd7;
    localparam logic [16:0] HDR_LEN_ADDR   = 17'd8;
    localparam logic [16:0] CRC_BYTES      = 17'd2;

    typedef enum logic [1:0] {
        FK_GOOD,
        FK_BAD_CRC,
        FK_BAD_VER,
        FK_BAD_SIZE
    } t_frame_kind;

    // Clock, reset and every block input start at known values.
    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic [7:0]        i_rx_byte   = 8'h00;
    logic              i_out_stall = 1'b0;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [APB_AW-1:0] paddr       = '0;
    logic [APB_DW-1:0] pwdata      = '0;

    logic              o_in_stall;
    logic              o_out_valid;
    logic [2:0]        o_event_res;
    logic [7:0]        o_byte_echo;
    logic [7:0]        o_frame_type;
    logic [7:0]        o_frame_version;
    logic              o_addressed;
    logic              o_data_bit;
    logic [3:0]        o_frame_class;
    logic [7:0]        o_message_id;
    logic [7:0]        o_device_addr;
    logic [SIZE_W-1:0] o_payload_size;
    logic [CRC_W-1:0]  o_computed_crc;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    framed_packet_parser_crc16 uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_rx_byte       (i_rx_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_event_res     (o_event_res),
        .o_byte_echo     (o_byte_echo),
        .o_frame_type    (o_frame_type),
        .o_frame_version (o_frame_version),
        .o_addressed     (o_addressed),
        .o_data_bit      (o_data_bit),
        .o_frame_class   (o_frame_class),
        .o_message_id    (o_message_id),
        .o_device_addr   (o_device_addr),
        .o_payload_size  (o_payload_size),
        .o_computed_crc  (o_computed_crc),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // Bytes waiting to be sent and events waiting to be seen.
    logic [7:0] rx_pending_q[$];
    t_result    event_expect_q[$];

    int  queued_cnt   = 0;
    int  accepted_cnt = 0;
    int  event_cnt    = 0;
    int  stim_cnt     = 0;
    int  err_cnt      = 0;
    int  cycle_cnt    = 0;
    bit  no_idle      = 1'b0;

    // Shadow of the parser configuration.
    logic [7:0]        cfg_head   = HEAD_BYTE_RST;
    logic [7:0]        cfg_maxver = MAX_VERSION_RST;
    logic [SIZE_W-1:0] cfg_maxpay = MAX_PAYLOAD_RST;

    // Shadow of the parser state.
    t_phase           st_phase  = PH_HUNT;
    logic [16:0]      st_count  = '0;
    logic [CRC_W-1:0] st_crc    = '0;
    logic [CRC_W-1:0] st_rx_crc = '0;
    logic [15:0]      st_size   = '0;
    logic [7:0]       st_type   = '0;
    logic [7:0]       st_ver    = '0;
    logic [5:0]       st_ctrl   = '0;
    logic [7:0]       st_mid    = '0;
    logic [7:0]       st_addr   = '0;

    t_result drv_event;
    t_result mon_want;
    t_result mon_got;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The run is cut off if it hangs.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // CRC-16/XMODEM, one data bit per step, MSB first.
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ data[i];
            c  = {c[14:0], 1'b0} ^ (fb ? 16'h1021 : 16'h0000);
        end
        return c;
    endfunction

    // Advance the shadow parser by one byte and form the event it reports.
    task automatic parse_byte(input logic [7:0] b, output t_result r);
        logic [16:0] hdr_len;
        t_event      ev;
        logic        failed;
        hdr_len = st_ctrl[CTRL_ADDR_BIT] ? HDR_LEN_ADDR : HDR_LEN_NOADDR;
        ev      = EV_HEADER;
        failed  = 1'b0;
        if (st_phase >= PH_TYPE && st_phase <= PH_DATA) begin
            st_crc = crc_step(st_crc, b);
        end
        if (st_phase != PH_HUNT) begin
            st_count = st_count + 17'd1;
        end
        case (st_phase)
            PH_HUNT: begin
                if (b == cfg_head) begin
                    st_count  = 17'd1;
                    st_crc    = '0;
                    st_rx_crc = '0;
                    st_size   = '0;
                    st_phase  = PH_TYPE;
                end else begin
                    ev = EV_HUNT;
                end
            end
            PH_TYPE: begin
                st_type  = b;
                st_phase = PH_VER;
            end
            PH_VER: begin
                st_ver = b;
                if (b <= cfg_maxver) begin
                    st_phase = PH_CTRL;
                end else begin
                    ev     = EV_VER_ERR;
                    failed = 1'b1;
                end
            end
            PH_CTRL: begin
                st_ctrl  = b[5:0];
                st_phase = PH_MID;
            end
            PH_MID: begin
                st_mid = b;
                if (st_ctrl[CTRL_ADDR_BIT]) begin
                    st_phase = PH_ADDR;
                end else begin
                    st_addr  = '0;
                    st_phase = PH_SIZE;
                end
            end
            PH_ADDR: begin
                st_addr  = b;
                st_phase = PH_SIZE;
            end
            PH_SIZE: begin
                st_size = {st_size[7:0], b};
                if (st_count >= hdr_len) begin
                    if (st_size > cfg_maxpay) begin
                        ev     = EV_SIZE_ERR;
                        failed = 1'b1;
                    end else if (st_size == 16'd0) begin
                        st_phase = PH_CRC;
                    end else begin
                        st_phase = PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                ev = EV_PAYLOAD;
                if (st_count >= hdr_len + st_size) begin
                    st_phase = PH_CRC;
                end
            end
            PH_CRC: begin
                ev        = EV_CRC_BYTE;
                st_rx_crc = {st_rx_crc[7:0], b};
                if (st_count >= hdr_len + CRC_BYTES + st_size) begin
                    if (st_rx_crc == st_crc) begin
                        ev       = EV_FRAME_OK;
                        st_phase = PH_HUNT;
                        st_count = '0;
                    end else begin
                        ev     = EV_CRC_ERR;
                        failed = 1'b1;
                    end
                end
            end
            default: begin
                st_phase = PH_HUNT;
                ev       = EV_HUNT;
            end
        endcase
        r.event_res     = ev;
        r.byte_echo     = b;
        r.frame_type    = st_type;
        r.frame_version = st_ver;
        r.addressed     = st_ctrl[CTRL_ADDR_BIT];
        r.data_bit      = st_ctrl[CTRL_DATA_BIT];
        r.frame_class   = st_ctrl[3:0];
        r.message_id    = st_mid;
        r.device_addr   = st_addr;
        r.payload_size  = st_size;
        r.computed_crc  = st_crc;
        // Any error drops the frame and returns to hunting.
        if (failed) begin
            st_phase = PH_HUNT;
            st_count = '0;
            st_size  = '0;
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS) begin
                $display("event %0d, %s: expected %h, got %h", event_cnt, name, want, got);
            end
        end
    endtask

    // Driver: presents pending bytes and predicts each accepted transaction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                parse_byte(i_rx_byte, drv_event);
                event_expect_q.push_back(drv_event);
                accepted_cnt++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (rx_pending_q.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
                    i_in_valid <= 1'b1;
                    i_rx_byte  <= rx_pending_q.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted event against the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                mon_got.event_res     = t_event'(o_event_res);
                mon_got.byte_echo     = o_byte_echo;
                mon_got.frame_type    = o_frame_type;
                mon_got.frame_version = o_frame_version;
                mon_got.addressed     = o_addressed;
                mon_got.data_bit      = o_data_bit;
                mon_got.frame_class   = o_frame_class;
                mon_got.message_id    = o_message_id;
                mon_got.device_addr   = o_device_addr;
                mon_got.payload_size  = o_payload_size;
                mon_got.computed_crc  = o_computed_crc;
                if (event_expect_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS) begin
                        $display("event %0d arrived with no byte pending: event %0d byte %h",
                                 event_cnt, o_event_res, o_byte_echo);
                    end
                end else begin
                    mon_want = event_expect_q.pop_front();
                    check_field("event_res", mon_want.event_res, mon_got.event_res);
                    check_field("byte_echo", mon_want.byte_echo, mon_got.byte_echo);
                    check_field("frame_type", mon_want.frame_type, mon_got.frame_type);
                    check_field("frame_version", mon_want.frame_version,
                                mon_got.frame_version);
                    check_field("addressed", mon_want.addressed, mon_got.addressed);
                    check_field("data_bit", mon_want.data_bit, mon_got.data_bit);
                    check_field("frame_class", mon_want.frame_class, mon_got.frame_class);
                    check_field("message_id", mon_want.message_id, mon_got.message_id);
                    check_field("device_addr", mon_want.device_addr, mon_got.device_addr);
                    check_field("payload_size", mon_want.payload_size, mon_got.payload_size);
                    check_field("computed_crc", mon_want.computed_crc, mon_got.computed_crc);
                end
                event_cnt++;
            end
            i_out_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
        end
    end

    task automatic put_byte(input logic [7:0] b, input bit counted);
        rx_pending_q.push_back(b);
        queued_cnt++;
        if (counted) begin
            stim_cnt++;
        end
    endtask

    // Queue one frame; negative requests mean a random choice.
    task automatic add_frame(input t_frame_kind kind, input int ctrl_req, input int ver_req,
                             input int size_req);
        logic [15:0] crc;
        logic [7:0]  b;
        logic [7:0]  ctrl;
        logic [7:0]  ver;
        int          size;
        int          pick;
        int          mp;
        int          mv;
        mp  = cfg_maxpay;
        mv  = cfg_maxver;
        crc = '0;
        put_byte(cfg_head, 1'b1);

        // Type and version.
        b = 8'($urandom);
        put_byte(b, 1'b1);
        crc = crc_step(crc, b);
        if (ver_req >= 0) begin
            ver = 8'(ver_req);
        end else if (kind == FK_BAD_VER) begin
            ver = 8'($urandom_range(mv + 1, 255));
        end else if ($urandom_range(3) == 0) begin
            ver = 8'(mv);
        end else begin
            ver = 8'($urandom_range(0, mv));
        end
        put_byte(ver, 1'b1);
        crc = crc_step(crc, ver);
        if (kind == FK_BAD_VER) begin
            return;
        end

        // Control, message id and the optional address.
        ctrl = (ctrl_req >= 0) ? 8'(ctrl_req) : 8'($urandom);
        put_byte(ctrl, 1'b1);
        crc = crc_step(crc, ctrl);
        b = 8'($urandom);
        put_byte(b, 1'b1);
        crc = crc_step(crc, b);
        if (ctrl[CTRL_ADDR_BIT]) begin
            b = 8'($urandom);
            put_byte(b, 1'b1);
            crc = crc_step(crc, b);
        end

        // Size: mostly short payloads, sometimes the configured maximum if at most 300.
        if (size_req >= 0) begin
            size = size_req;
        end else if (kind == FK_BAD_SIZE) begin
            size = $urandom_range(1) ? mp + 1 : $urandom_range(mp + 1, 65535);
        end else begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                size = 0;
            end else if (pick < 88) begin
                size = $urandom_range(0, (mp < 12) ? mp : 12);
            end else if (pick < 96) begin
                size = $urandom_range(0, (mp < 300) ? mp : 300);
            end else begin
                size = (mp <= 300) ? mp : $urandom_range(0, 300);
            end
        end
        b = size[15:8];
        put_byte(b, 1'b1);
        crc = crc_step(crc, b);
        b = size[7:0];
        put_byte(b, 1'b1);
        crc = crc_step(crc, b);
        if (kind == FK_BAD_SIZE) begin
            return;
        end

        for (int i = 0; i < size; i++) begin
            b = 8'($urandom);
            put_byte(b, 1'b1);
            crc = crc_step(crc, b);
        end
        if (kind == FK_BAD_CRC) begin
            crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
        end
        put_byte(crc[15:8], 1'b1);
        put_byte(crc[7:0], 1'b1);
    endtask

    // Mostly well-formed frames, with broken frames and line noise mixed in.
    task automatic add_random_traffic(input int budget);
        int         pick;
        int         n;
        logic [7:0] b;
        stim_cnt = 0;
        while (stim_cnt < budget) begin
            pick = $urandom_range(99);
            if (pick < 62) begin
                add_frame(FK_GOOD, -1, -1, -1);
            end else if (pick < 74) begin
                add_frame(FK_BAD_CRC, -1, -1, -1);
            end else if (pick < 81 && cfg_maxver != 8'hFF) begin
                add_frame(FK_BAD_VER, -1, -1, -1);
            end else if (pick < 88 && cfg_maxpay != 16'hFFFF) begin
                add_frame(FK_BAD_SIZE, -1, -1, -1);
            end else if (pick < 93) begin
                // A head followed by a short run of junk, so the next frame is misparsed.
                put_byte(cfg_head, 1'b1);
                n = $urandom_range(1, 6);
                repeat (n) put_byte(8'($urandom), 1'b1);
            end else begin
                // Line noise between frames rarely hits the head byte.
                n = $urandom_range(1, 8);
                repeat (n) begin
                    b = 8'($urandom);
                    if (b == cfg_head && $urandom_range(9) != 0) begin
                        b = ~b;
                    end
                    put_byte(b, 1'b0);
                end
            end
        end
    endtask

    // Wait until every queued byte has been accepted and every event seen.
    task automatic drain;
        while (!(accepted_cnt == queued_cnt && event_expect_q.size() == 0)) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [APB_DW-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({idx, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(input logic [7:0] head, input logic [7:0] maxver,
                              input logic [15:0] maxpay);
        drain();
        apb_write(REG_HEAD_BYTE, APB_DW'(head));
        apb_write(REG_MAX_VERSION, APB_DW'(maxver));
        apb_write(REG_MAX_PAYLOAD, APB_DW'(maxpay));
        cfg_head   = head;
        cfg_maxver = maxver;
        cfg_maxpay = maxpay;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes of noise, a zero-length addressed frame at the top
        // version, a version error, a size error on the largest size and a short frame.
        put_byte(8'h00, 1'b1);
        put_byte(8'hFF, 1'b1);
        add_frame(FK_GOOD, 8'hFF, int'(cfg_maxver), 0);
        add_frame(FK_BAD_VER, 8'h00, 8'hFF, -1);
        add_frame(FK_BAD_SIZE, 8'h10, 0, 16'hFFFF);
        add_frame(FK_GOOD, 8'h00, 0, 3);

        add_random_traffic(400);

        // Lowest settings: only version 0 and empty payloads pass. The write to
        // the unused address must leave the parser alone.
        set_config(8'h00, 8'h00, 16'h0000);
        apb_write(REG_UNUSED, 32'hFFFF_FFFF);
        add_random_traffic(350);

        // Highest settings, run without any idle cycles.
        set_config(8'hFF, 8'hFF, 16'hFFFF);
        no_idle = 1'b1;
        add_random_traffic(350);
        drain();
        no_idle = 1'b0;

        set_config(8'($urandom), 8'($urandom_range(0, 5)), 16'($urandom_range(1, 40)));
        add_random_traffic(400);

        set_config(8'($urandom), 8'hFE, 16'hFFFE);
        add_random_traffic(400);

        drain();
        repeat (10) @(posedge i_clk);
        if (err_cnt == 0 && event_expect_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: framed_packet_parser_crc16.f
rtl/fpp_pkg.sv
rtl/fpp_apb_regs.sv
rtl/fpp_parse_core.sv
rtl/framed_packet_parser_crc16.sv
tb/tb_framed_packet_parser_crc16.sv
